FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check under reset
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication check under reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

FILE: rtl/ftsst_pkg.sv
// shared types and codes for the task scheduler
// no dependencies
package ftsst_pkg;

    localparam logic [2:0] ACT_CREATE    = 3'd0;
    localparam logic [2:0] ACT_SLEEP     = 3'd1;
    localparam logic [2:0] ACT_TERMINATE = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_QUERY     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_NO_RUN   = 2'd2;
    localparam logic [1:0] ST_BAD_ACT  = 2'd3;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_READY    = 2'd1;
    localparam logic [1:0] SLOT_SLEEPING = 2'd2;
    localparam logic [1:0] SLOT_RETIRED  = 2'd3;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_MUL,
        FSM_WALK,
        FSM_DONE
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture item fields
        logic scan_step;  // test one slot for create
        logic scan_clr;
        logic exec;       // apply terminate, query, bad-action and tick-charge effects
        logic mul_commit; // finish sleep
        logic walk_clr;
        logic walk_step;  // process one sleeper
        logic walk_end;
        logic report;     // drive result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic walk_done;
    } ctrl_stat_t;

endpackage

FILE: rtl/fifo_task_scheduler_sleep_timers_unit.sv
// top level of the task scheduler with sleep timers
// depends on ftsst_pkg, ftsst_ctrl, ftsst_dp
// an item is taken when start is high and busy low; its one result appears
// with done high for a single cycle and cannot be held off by the receiver.
// query, terminate and bad actions go from idle straight to the result
// state; sleep passes through a state that commits the seconds times rate
// product, create scans slots until a free one is found (up to MAX_TASKS),
// and tick walks every sleeper before the result. busy stays high
// through the result cycle. ticks_per_second may be written whenever idle.
module fifo_task_scheduler_sleep_timers_unit #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] sleep_seconds,
    input  logic        user_mode,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic        running_valid,
    output logic [3:0]  running_task,
    output logic [3:0]  created_task,
    output logic [31:0] user_ticks,
    output logic [31:0] system_ticks,
    output logic [31:0] total_ticks
);

    ftsst_pkg::ctrl_cmd_t  cmd;
    ftsst_pkg::ctrl_stat_t stat;
    logic ctrl_busy;

    // controller sequences each item; no item is taken in the result cycle
    ftsst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !done),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (ctrl_busy)
    );

    // busy covers the result cycle too
    assign busy = ctrl_busy || done;

    ftsst_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .sleep_seconds (sleep_seconds),
        .user_mode     (user_mode),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .running_valid (running_valid),
        .running_task  (running_task),
        .created_task  (created_task),
        .user_ticks    (user_ticks),
        .system_ticks  (system_ticks),
        .total_ticks   (total_ticks)
    );

endmodule

FILE: rtl/ftsst_ctrl.sv
// controller state machine for the task scheduler
// depends on ftsst_pkg
module ftsst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            action,
    input  ftsst_pkg::ctrl_stat_t stat,
    output ftsst_pkg::ctrl_cmd_t  cmd,
    output logic                  busy
);

    ftsst_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftsst_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftsst_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    priority if (action == ftsst_pkg::ACT_CREATE)
                        state_next = ftsst_pkg::FSM_SCAN;
                    else if (action == ftsst_pkg::ACT_SLEEP)
                        state_next = ftsst_pkg::FSM_MUL;
                    else if (action == ftsst_pkg::ACT_TICK)
                        state_next = ftsst_pkg::FSM_WALK;
                    else
                        state_next = ftsst_pkg::FSM_DONE;
                end
            end
            ftsst_pkg::FSM_SCAN:
                if (stat.scan_done) state_next = ftsst_pkg::FSM_DONE;
            ftsst_pkg::FSM_MUL:
                state_next = ftsst_pkg::FSM_DONE;
            ftsst_pkg::FSM_WALK:
                if (stat.walk_done) state_next = ftsst_pkg::FSM_DONE;
            ftsst_pkg::FSM_DONE:
                state_next = ftsst_pkg::FSM_IDLE;
            default:
                state_next = ftsst_pkg::FSM_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ftsst_pkg::FSM_IDLE);
        unique case (state_reg)
            ftsst_pkg::FSM_IDLE:
            begin
                cmd.latch    = start;
                cmd.scan_clr = start;
                cmd.walk_clr = start;
                // tick charges and bad/terminate/query act at once
                cmd.exec     = start && action != ftsst_pkg::ACT_CREATE
                               && action != ftsst_pkg::ACT_SLEEP;
            end
            ftsst_pkg::FSM_SCAN: cmd.scan_step = 1'b1;
            ftsst_pkg::FSM_MUL:  cmd.mul_commit = 1'b1;
            ftsst_pkg::FSM_WALK:
            begin
                cmd.walk_step = !stat.walk_done;
                cmd.walk_end  = stat.walk_done;
            end
            ftsst_pkg::FSM_DONE: cmd.report = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/ftsst_dp.sv
// datapath: task table, ready ring, sleep list, counters
// depends on ftsst_pkg
module ftsst_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ftsst_pkg::ctrl_cmd_t  cmd,
    output ftsst_pkg::ctrl_stat_t stat,
    input  logic [2:0]            action,
    input  logic [15:0]           sleep_seconds,
    input  logic                  user_mode,
    input  logic                  cfg_we,
    input  logic [9:0]            cfg_data,
    output logic                  done,
    output logic [1:0]            status,
    output logic                  running_valid,
    output logic [3:0]            running_task,
    output logic [3:0]            created_task,
    output logic [31:0]           user_ticks,
    output logic [31:0]           system_ticks,
    output logic [31:0]           total_ticks
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

    logic [9:0]    tps_reg;
    logic [1:0]    slot_reg   [MAX_TASKS];
    logic [IW-1:0] rq_reg     [MAX_TASKS];
    logic [IW-1:0] sq_reg     [MAX_TASKS];
    logic [31:0]   cd_reg     [MAX_TASKS];
    logic [31:0]   ut_reg     [MAX_TASKS];
    logic [31:0]   st_reg     [MAX_TASKS];
    logic [IW-1:0] rhead_reg;
    logic [CW-1:0] rcnt_reg;
    logic [CW-1:0] scnt_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] kept_reg;
    logic [31:0]   gt_reg;
    logic [1:0]    stat_reg;
    logic [IW-1:0] created_reg;
    logic          found_reg;

    logic [IW-1:0] run, push_pos, s_cur, idx_i;
    logic [31:0]   cd_dec;
    logic          wake;

    assign run    = rq_reg[rhead_reg];
    assign idx_i  = idx_reg[IW-1:0];
    assign s_cur  = sq_reg[idx_i];
    assign cd_dec = cd_reg[s_cur] - 32'd1;
    assign wake   = (cd_dec == 32'd0) || cd_dec[31];

    always_comb
    begin
        logic [CW:0] p;
        p = {1'b0, CW'(rhead_reg)} + {1'b0, rcnt_reg};
        if (p >= (CW+1)'(MAX_TASKS))
            p = p - (CW+1)'(MAX_TASKS);
        push_pos = p[IW-1:0];
    end

    assign stat.scan_done = found_reg || idx_reg == CW'(MAX_TASKS);
    assign stat.walk_done = idx_reg >= scnt_reg;

    // 26-bit product of seconds and rate, taken with the item
    logic [25:0] prod_reg;
    always_ff @(posedge clk)
        if (cmd.latch)
            prod_reg <= 26'(sleep_seconds) * 26'(tps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= 10'd100;
            rhead_reg <= '0;
            rcnt_reg  <= '0;
            scnt_reg  <= '0;
            idx_reg   <= '0;
            kept_reg  <= '0;
            gt_reg    <= '0;
            stat_reg  <= ftsst_pkg::ST_OK;
            created_reg <= '0;
            found_reg <= 1'b0;
            done      <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_reg[i] <= ftsst_pkg::SLOT_FREE;
                cd_reg[i]   <= '0;
                ut_reg[i]   <= '0;
                st_reg[i]   <= '0;
            end
        end
        else
        begin
            done <= cmd.report;
            if (cfg_we)
                tps_reg <= cfg_data;
            if (cmd.latch)
            begin
                stat_reg <= ftsst_pkg::ST_OK;
                created_reg <= '0;
                found_reg <= 1'b0;
                if (action == ftsst_pkg::ACT_SLEEP &&
                    (rcnt_reg == '0 || scnt_reg >= CW'(MAX_TASKS)))
                    stat_reg <= ftsst_pkg::ST_NO_RUN;
            end
            if (cmd.scan_clr || cmd.walk_clr)
            begin
                idx_reg  <= '0;
                kept_reg <= '0;
            end
            if (cmd.exec)
            begin
                unique case (action)
                    ftsst_pkg::ACT_TERMINATE:
                        if (rcnt_reg == '0)
                            stat_reg <= ftsst_pkg::ST_NO_RUN;
                        else
                        begin
                            slot_reg[run] <= ftsst_pkg::SLOT_RETIRED;
                            rhead_reg <= (rhead_reg == LAST) ? '0 : rhead_reg + 1'b1;
                            rcnt_reg  <= rcnt_reg - 1'b1;
                        end
                    ftsst_pkg::ACT_TICK:
                    begin
                        gt_reg <= gt_reg + 32'd1;
                        if (rcnt_reg != '0)
                        begin
                            if (user_mode) ut_reg[run] <= ut_reg[run] + 32'd1;
                            else           st_reg[run] <= st_reg[run] + 32'd1;
                        end
                    end
                    ftsst_pkg::ACT_QUERY: ;
                    ftsst_pkg::ACT_CREATE, ftsst_pkg::ACT_SLEEP: ;
                    default: stat_reg <= ftsst_pkg::ST_BAD_ACT;
                endcase
            end
            if (cmd.scan_step && !stat.scan_done)
            begin
                if (slot_reg[idx_i] == ftsst_pkg::SLOT_FREE)
                begin
                    found_reg   <= 1'b1;
                    created_reg <= idx_i;
                    slot_reg[idx_i] <= ftsst_pkg::SLOT_READY;
                    cd_reg[idx_i]   <= '0;
                    if (rcnt_reg < CW'(MAX_TASKS))
                    begin
                        rq_reg[push_pos] <= idx_i;
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.scan_step && stat.scan_done && !found_reg)
                stat_reg <= ftsst_pkg::ST_NO_SLOT;
            if (cmd.mul_commit && stat_reg == ftsst_pkg::ST_OK)
            begin
                cd_reg[run]   <= 32'(prod_reg);
                slot_reg[run] <= ftsst_pkg::SLOT_SLEEPING;
                sq_reg[scnt_reg[IW-1:0]] <= run;
                scnt_reg  <= scnt_reg + 1'b1;
                rhead_reg <= (rhead_reg == LAST) ? '0 : rhead_reg + 1'b1;
                rcnt_reg  <= rcnt_reg - 1'b1;
            end
            if (cmd.walk_step)
            begin
                cd_reg[s_cur] <= cd_dec;
                idx_reg <= idx_reg + 1'b1;
                if (wake)
                begin
                    slot_reg[s_cur] <= ftsst_pkg::SLOT_READY;
                    if (rcnt_reg < CW'(MAX_TASKS))
                    begin
                        rq_reg[push_pos] <= s_cur;
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end
                else
                begin
                    sq_reg[kept_reg[IW-1:0]] <= s_cur;
                    kept_reg <= kept_reg + 1'b1;
                end
            end
            if (cmd.walk_end)
                scnt_reg <= kept_reg;
        end
    end

    // result is valid in the cycle after report, alongside done
    logic rv;
    assign rv            = rcnt_reg != '0;
    assign status        = stat_reg;
    assign running_valid = rv;
    assign running_task  = rv ? 4'(run) : 4'd0;
    assign created_task  = 4'(created_reg);
    assign user_ticks    = rv ? ut_reg[run] : 32'd0;
    assign system_ticks  = rv ? st_reg[run] : 32'd0;
    assign total_ticks   = gt_reg;

endmodule

FILE: rtl/ftsst_checker.sv
// port-level checker for the task scheduler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ftsst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        running_valid,
    input logic [3:0]  running_task,
    input logic [31:0] user_ticks,
    input logic [31:0] total_ticks
);
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_IMPL(a_idle_run, clk, rst_n, done && !running_valid,
                 running_task == 4'd0 && user_ticks == 32'd0)
    `ASSERT_IMPL(a_ticks_hold, clk, rst_n, !busy && $past(!busy), $stable(total_ticks))
endmodule

bind fifo_task_scheduler_sleep_timers_unit ftsst_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .running_valid (running_valid),
    .running_task  (running_task),
    .user_ticks    (user_ticks),
    .total_ticks   (total_ticks)
);

FILE: dv/tb_fifo_task_scheduler_sleep_timers_unit.sv
// self-checking testbench for the task scheduler with sleep timers
// depends on ftsst_pkg and fifo_task_scheduler_sleep_timers_unit
`timescale 1ns / 1ps

module tb_fifo_task_scheduler_sleep_timers_unit;

    localparam int NSLOT = 16;
    localparam int WDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  action = ftsst_pkg::ACT_QUERY;
    logic [15:0] sleep_seconds = '0;
    logic        user_mode = 1'b0;
    logic        cfg_we = 1'b0;
    logic [9:0]  cfg_data = '0;
    logic        done;
    logic [1:0]  status;
    logic        running_valid;
    logic [3:0]  running_task;
    logic [3:0]  created_task;
    logic [31:0] user_ticks;
    logic [31:0] system_ticks;
    logic [31:0] total_ticks;

    typedef struct packed {
        logic [1:0]  status;
        logic        running_valid;
        logic [3:0]  running_task;
        logic [3:0]  created_task;
        logic [31:0] user_ticks;
        logic [31:0] system_ticks;
        logic [31:0] total_ticks;
    } sched_report_t;

    // directed row: item fields, plus an optional typed-in status
    typedef struct {
        logic [2:0]  act;
        logic [15:0] secs;
        logic        usr;
        bit          fixed;
        logic [1:0]  want_status;
    } stim_row_t;

    always #5 clk = ~clk;

    fifo_task_scheduler_sleep_timers_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .sleep_seconds(sleep_seconds), .user_mode(user_mode),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .status(status),
        .running_valid(running_valid), .running_task(running_task),
        .created_task(created_task), .user_ticks(user_ticks),
        .system_ticks(system_ticks), .total_ticks(total_ticks)
    );

    // ---------------- scheduler shadow state ----------------
    logic [9:0]  rate;
    logic [1:0]  slot_state [NSLOT];
    logic [3:0]  ready_q [$];
    logic [3:0]  sleepers [$];
    logic [31:0] wake_count [NSLOT];
    logic [31:0] user_cnt [NSLOT];
    logic [31:0] sys_cnt [NSLOT];
    logic [31:0] tick_total;

    sched_report_t pending_reports [$];
    int          errors = 0;
    int          idle_cycles = 0;

    function automatic void shadow_reset();
        rate = 10'd100;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_state[i] = ftsst_pkg::SLOT_FREE;
            wake_count[i] = '0;
            user_cnt[i] = '0;
            sys_cnt[i] = '0;
        end
        ready_q.delete();
        sleepers.delete();
        tick_total = '0;
    endfunction

    // advance the shadow by one item and return the report it should give
    function automatic sched_report_t schedule_step(logic [2:0] act, logic [15:0] secs,
                                                   logic usr);
        sched_report_t r;
        logic [3:0]  run;
        logic [3:0]  keep [$];
        logic [31:0] c;
        r = '0;
        case (act)
            ftsst_pkg::ACT_CREATE:
            begin
                r.status = ftsst_pkg::ST_NO_SLOT;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (slot_state[i] == ftsst_pkg::SLOT_FREE)
                    begin
                        slot_state[i] = ftsst_pkg::SLOT_READY;
                        wake_count[i] = '0;
                        ready_q.push_back(4'(i));
                        r.created_task = 4'(i);
                        r.status = ftsst_pkg::ST_OK;
                        break;
                    end
                end
            end
            ftsst_pkg::ACT_SLEEP:
            begin
                if (ready_q.size() == 0 || sleepers.size() >= NSLOT)
                    r.status = ftsst_pkg::ST_NO_RUN;
                else
                begin
                    run = ready_q.pop_front();
                    wake_count[run] = 32'(secs) * 32'(rate);
                    slot_state[run] = ftsst_pkg::SLOT_SLEEPING;
                    sleepers.push_back(run);
                end
            end
            ftsst_pkg::ACT_TERMINATE:
            begin
                if (ready_q.size() == 0)
                    r.status = ftsst_pkg::ST_NO_RUN;
                else
                begin
                    run = ready_q.pop_front();
                    slot_state[run] = ftsst_pkg::SLOT_RETIRED;
                end
            end
            ftsst_pkg::ACT_TICK:
            begin
                tick_total++;
                if (ready_q.size() != 0)
                begin
                    if (usr)
                        user_cnt[ready_q[0]]++;
                    else
                        sys_cnt[ready_q[0]]++;
                end
                // walk sleepers in order; signed compare, so a wrap from zero wakes
                foreach (sleepers[k])
                begin
                    c = wake_count[sleepers[k]] - 32'd1;
                    wake_count[sleepers[k]] = c;
                    if (c == 0 || c[31])
                    begin
                        slot_state[sleepers[k]] = ftsst_pkg::SLOT_READY;
                        ready_q.push_back(sleepers[k]);
                    end
                    else
                        keep.push_back(sleepers[k]);
                end
                sleepers = keep;
            end
            ftsst_pkg::ACT_QUERY: ;
            default: r.status = ftsst_pkg::ST_BAD_ACT;
        endcase
        r.running_valid = ready_q.size() != 0;
        if (ready_q.size() != 0)
        begin
            r.running_task = ready_q[0];
            r.user_ticks = user_cnt[ready_q[0]];
            r.system_ticks = sys_cnt[ready_q[0]];
        end
        r.total_ticks = tick_total;
        return r;
    endfunction

    // ---------------- driving ----------------
    task automatic send_item(logic [2:0] act, logic [15:0] secs, logic usr, bit fixed,
                             logic [1:0] want);
        sched_report_t r;
        start <= 1'b1;
        action <= act;
        sleep_seconds <= secs;
        user_mode <= usr;
        do @(posedge clk); while (busy);
        r = schedule_step(act, secs, usr);
        if (fixed && r.status != want)
        begin
            $display("%0t: directed status expected %0d, predictor %0d", $time, want,
                     r.status);
            errors++;
        end
        pending_reports.push_back(r);
        start <= 1'b0;
        // the block is busy after an item, so this edge costs nothing
        @(posedge clk);
    endtask

    // random gap between bursts
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_rate(logic [9:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate = v;
    endtask

    // random item: mostly well-formed work, some noise and bad actions
    task automatic random_item();
        logic [2:0]  act;
        logic [15:0] secs;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 12) act = ftsst_pkg::ACT_CREATE;
        else if (p < 24) act = ftsst_pkg::ACT_SLEEP;
        else if (p < 30) act = ftsst_pkg::ACT_TERMINATE;
        else if (p < 85) act = ftsst_pkg::ACT_TICK;
        else if (p < 95) act = ftsst_pkg::ACT_QUERY;
        else act = 3'($urandom_range(5, 7));
        // short sleeps so tasks come back often; now and then any length
        p = $urandom_range(0, 19);
        if (p == 0) secs = 16'($urandom);
        else if (p < 4) secs = 16'd0;
        else secs = 16'($urandom_range(1, 3));
        send_item(act, secs, 1'($urandom), 1'b0, ftsst_pkg::ST_OK);
    endtask

    // ---------------- checking ----------------
    always @(posedge clk)
    begin
        sched_report_t got, want;
        if (rst_n && done)
        begin
            got = '{status, running_valid, running_task, created_task, user_ticks,
                    system_ticks, total_ticks};
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.status != want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                if (got.running_valid != want.running_valid)
                    $display("%0t: running_valid expected %0d actual %0d", $time,
                             want.running_valid, got.running_valid);
                if (got.running_task != want.running_task)
                    $display("%0t: running_task expected %0d actual %0d", $time,
                             want.running_task, got.running_task);
                if (got.created_task != want.created_task)
                    $display("%0t: created_task expected %0d actual %0d", $time,
                             want.created_task, got.created_task);
                if (got.user_ticks != want.user_ticks)
                    $display("%0t: user_ticks expected %0d actual %0d", $time,
                             want.user_ticks, got.user_ticks);
                if (got.system_ticks != want.system_ticks)
                    $display("%0t: system_ticks expected %0d actual %0d", $time,
                             want.system_ticks, got.system_ticks);
                if (got.total_ticks != want.total_ticks)
                    $display("%0t: total_ticks expected %0d actual %0d", $time,
                             want.total_ticks, got.total_ticks);
                if (got != want)
                    errors++;
            end
        end
    end

    // watchdog: cycles with neither an item taken nor a result seen
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb_fifo_task_scheduler_sleep_timers_unit: errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    stim_row_t plan [] = '{
        '{ftsst_pkg::ACT_QUERY,     16'd0,    1'b0, 1'b1, ftsst_pkg::ST_OK}, // nothing running
        '{ftsst_pkg::ACT_SLEEP,     16'd5,    1'b0, 1'b1, ftsst_pkg::ST_NO_RUN},
        '{ftsst_pkg::ACT_TERMINATE, 16'd0,    1'b0, 1'b1, ftsst_pkg::ST_NO_RUN},
        '{ftsst_pkg::ACT_TICK,      16'd0,    1'b1, 1'b1, ftsst_pkg::ST_OK}, // empty table
        '{3'd5,                     16'd0,    1'b0, 1'b1, ftsst_pkg::ST_BAD_ACT},
        '{3'd6,                     16'hffff, 1'b1, 1'b1, ftsst_pkg::ST_BAD_ACT},
        '{3'd7,                     16'hffff, 1'b1, 1'b1, ftsst_pkg::ST_BAD_ACT},
        '{ftsst_pkg::ACT_CREATE,    16'd0,    1'b0, 1'b1, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_CREATE,    16'hffff, 1'b1, 1'b1, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_TICK,      16'd0,    1'b1, 1'b0, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_TICK,      16'd0,    1'b0, 1'b0, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_SLEEP,     16'd0,    1'b0, 1'b0, ftsst_pkg::ST_OK}, // wakes next tick
        '{ftsst_pkg::ACT_TICK,      16'd0,    1'b0, 1'b0, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_SLEEP,     16'hffff, 1'b0, 1'b0, ftsst_pkg::ST_OK}, // longest sleep
        '{ftsst_pkg::ACT_TERMINATE, 16'd0,    1'b0, 1'b0, ftsst_pkg::ST_OK},
        '{ftsst_pkg::ACT_QUERY,     16'd0,    1'b0, 1'b0, ftsst_pkg::ST_OK}
    };

    initial
    begin
        shadow_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].act, plan[i].secs, plan[i].usr, plan[i].fixed,
                      plan[i].want_status);
        // fill the table until create is refused
        repeat (16) send_item(ftsst_pkg::ACT_CREATE, 16'd0, 1'b0, 1'b0, ftsst_pkg::ST_OK);

        // zero multiplier: every sleep wakes on the next tick
        write_rate(10'd0);
        repeat (6) send_item(ftsst_pkg::ACT_SLEEP, 16'($urandom), 1'b0, 1'b0,
                             ftsst_pkg::ST_OK);
        send_item(ftsst_pkg::ACT_TICK, 16'd0, 1'b1, 1'b0, ftsst_pkg::ST_OK);

        // random phases over several rates, extremes among them
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_rate(10'd1);
                1: write_rate(10'd2);
                2: write_rate(10'd1000);
                3: write_rate(10'h3ff);
                default: write_rate(10'($urandom_range(1, 5)));
            endcase
            for (int n = 0; n < 200; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    idle_gap();
                random_item();
                // occasionally let everything come back before going on
                if ($urandom_range(0, 99) == 0)
                    while (pending_reports.size() != 0) @(posedge clk);
            end
            // the table is already full before these phases and slots never return,
            // so no create succeeds here, which the mix allows
        end

        drain();
        if (errors == 0)
            $display("tb_fifo_task_scheduler_sleep_timers_unit: clean");
        else
            $display("tb_fifo_task_scheduler_sleep_timers_unit: errors");
        $finish;
    end

endmodule
